FILE: hdl/pbrle_pkg.sv
// Shared types and constants for the PackBits run-length encoder.
`default_nettype none

package pbrle_pkg;

    localparam int BYTE_W      = 8;
    localparam int OP_W        = 2;
    localparam int OUT_W       = 64;
    localparam int OUT_COUNT_W = 4;
    localparam int OUT_LANES   = OUT_W / BYTE_W;

    localparam logic [OP_W-1:0] OP_PUT     = 2'd0;
    localparam logic [OP_W-1:0] OP_FINAL   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef enum logic [1:0] {
        KIND_UNDET   = 2'd0,
        KIND_REPEAT  = 2'd1,
        KIND_LITERAL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FLUSH = 2'd1,
        S_ERROR = 2'd2
    } t_state;

    typedef struct packed {
        logic apply;       // update run state for an item that emits nothing
        logic capture;     // latch the item that closes a run, start the flush
        logic step;        // push the next encoded byte into the packer
        logic post_error;  // place the error item into the output register
    } t_cmd;

    typedef struct packed {
        logic need_err;
        logic need_flush;
        logic slot_free;
        logic flush_done;
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/packbits_rle_encoder.sv
// Top level of the PackBits run-length encoder.
//
//   channel | signals                                   | direction | payload
//   --------+-------------------------------------------+-----------+---------------------------
//   input   | i_in_valid / o_in_ready                   | in        | i_op, i_in_byte
//   output  | o_out_valid / i_out_ready                 | out       | o_out_bytes, o_out_count,
//           |                                           |           | o_last, o_status
//
// A put that closes no run only updates the run, so plain bytes stream at one per cycle.
// A put or finalize that closes a run is captured and flushed as its encoded bytes
// (2 for a repeat run, run length + 1 for a literal run, up to MAX_RUN + 1); the packer
// takes one byte per cycle from the single read port of the run buffer unless stalled.
// An item that hits a finished stream gets an error transfer once the output slot is free.
// A stalled output holds the packer and with it the input; the output register lets
// the next item transfer while the previous result still waits.
// Reset (i_rst_n low, synchronous) empties the run and clears the finished flag;
// the run buffer needs no clearing, since only written entries are read.
`default_nettype none

module packbits_rle_encoder #(
    parameter int MAX_RUN          = 128,
    parameter int BYTES_PER_RESULT = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [pbrle_pkg::OP_W-1:0]          i_op,
    input  wire logic [pbrle_pkg::BYTE_W-1:0]        i_in_byte,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [pbrle_pkg::OUT_W-1:0]              o_out_bytes,
    output logic [pbrle_pkg::OUT_COUNT_W-1:0]        o_out_count,
    output logic                                     o_last,
    output logic                                     o_status
);

    pbrle_pkg::t_cmd    cmd;
    pbrle_pkg::t_status status;

    // sequence accepts, flushes and error transfers
    pbrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // hold the run, encode and pack bytes, drive the output register
    pbrle_datapath #(
        .MAX_RUN          (MAX_RUN),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_op),
        .i_in_byte    (i_in_byte),
        .i_out_ready  (i_out_ready),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_out_bytes  (o_out_bytes),
        .o_out_count  (o_out_count),
        .o_last       (o_last),
        .o_status_bit (o_status)
    );

endmodule

`default_nettype wire

FILE: hdl/pbrle_ctrl.sv
// Controller state machine of the PackBits run-length encoder.
`default_nettype none

module pbrle_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  pbrle_pkg::t_status    i_status,
    output logic                  o_in_ready,
    output pbrle_pkg::t_cmd       o_cmd
);

    pbrle_pkg::t_state r_state;
    pbrle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbrle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pbrle_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.need_err) begin
                        n_state = pbrle_pkg::S_ERROR;
                    end else if (i_status.need_flush) begin
                        n_state = pbrle_pkg::S_FLUSH;
                    end
                end
            end
            pbrle_pkg::S_FLUSH: begin
                if (i_status.flush_done) begin
                    n_state = pbrle_pkg::S_IDLE;
                end
            end
            pbrle_pkg::S_ERROR: begin
                if (i_status.slot_free) begin
                    n_state = pbrle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbrle_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            pbrle_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.apply   = i_in_valid && !i_status.need_err && !i_status.need_flush;
                o_cmd.capture = i_in_valid && !i_status.need_err && i_status.need_flush;
            end
            pbrle_pkg::S_FLUSH: begin
                o_cmd.step = 1'b1;
            end
            pbrle_pkg::S_ERROR: begin
                o_cmd.post_error = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/pbrle_datapath.sv
// Datapath of the PackBits run-length encoder: run state, run buffer, packer, output register.
`default_nettype none

module pbrle_datapath #(
    parameter int MAX_RUN          = 128,
    parameter int BYTES_PER_RESULT = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [pbrle_pkg::OP_W-1:0]          i_op,
    input  wire logic [pbrle_pkg::BYTE_W-1:0]        i_in_byte,
    input  wire logic                                i_out_ready,
    input  pbrle_pkg::t_cmd                          i_cmd,
    output pbrle_pkg::t_status                       o_status,
    output logic                                     o_out_valid,
    output logic [pbrle_pkg::OUT_W-1:0]              o_out_bytes,
    output logic [pbrle_pkg::OUT_COUNT_W-1:0]        o_out_count,
    output logic                                     o_last,
    output logic                                     o_status_bit
);

    localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int LW = $clog2(MAX_RUN + 1);
    localparam int PW = $clog2(MAX_RUN + 2);
    localparam int CW = $clog2(BYTES_PER_RESULT + 1);
    localparam int BW = pbrle_pkg::BYTE_W;

    // run state
    logic [LW-1:0]      r_len,      n_len;
    pbrle_pkg::t_kind   r_kind,     n_kind;
    logic               r_finished, n_finished;
    logic [BW-1:0]      r_first,    n_first;
    logic [BW-1:0]      r_prev,     n_prev;

    // flush state
    logic [BW-1:0]      r_pend_byte, n_pend_byte;
    logic               r_pend_fin,  n_pend_fin;
    logic               r_flush_rep, n_flush_rep;
    logic [PW-1:0]      r_last_pos,  n_last_pos;
    logic [PW-1:0]      r_pos,       n_pos;
    logic [pbrle_pkg::OUT_W-1:0] r_acc, n_acc;
    logic [CW-1:0]      r_acc_cnt,   n_acc_cnt;

    // output register
    logic                                r_out_valid,  n_out_valid;
    logic [pbrle_pkg::OUT_W-1:0]         r_out_bytes,  n_out_bytes;
    logic [pbrle_pkg::OUT_COUNT_W-1:0]   r_out_count,  n_out_count;
    logic                                r_out_last,   n_out_last;
    logic                                r_out_status, n_out_status;

    // run buffer
    logic [BW-1:0]      r_mem [MAX_RUN];
    logic [BW-1:0]      r_mem_q;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [BW-1:0]      mem_wd;
    logic [AW-1:0]      mem_ra;

    logic               slot_free;
    logic               is_put;
    logic               is_fin;
    logic               rep_break;
    logic               lit_break;
    logic [BW-1:0]      rep_hdr;
    logic [BW-1:0]      lit_hdr;
    logic [BW-1:0]      cur_byte;
    logic               is_last;
    logic               completing;
    logic               advance;
    logic [pbrle_pkg::OUT_W-1:0] packed_word;

    always_comb begin
        slot_free = !r_out_valid || i_out_ready;
        is_put    = (i_op == pbrle_pkg::OP_PUT);
        is_fin    = (i_op == pbrle_pkg::OP_FINAL);
        rep_break = (r_kind == pbrle_pkg::KIND_REPEAT)
                 && !((r_len < LW'(MAX_RUN)) && (i_in_byte == r_first));
        lit_break = (r_kind == pbrle_pkg::KIND_LITERAL)
                 && !((r_len < LW'(MAX_RUN)) && (i_in_byte != r_prev));

        rep_hdr  = BW'(9'd257 - 9'(r_len));
        lit_hdr  = BW'(r_len - LW'(1));
        if (r_pos == '0) begin
            cur_byte = r_flush_rep ? rep_hdr : lit_hdr;
        end else begin
            cur_byte = r_flush_rep ? r_first : r_mem_q;
        end
        is_last    = (r_pos == r_last_pos);
        completing = is_last
                  || ((4'(r_acc_cnt) + 4'd1) == 4'(BYTES_PER_RESULT));
        advance    = i_cmd.step && (!completing || slot_free);

        for (int j = 0; j < pbrle_pkg::OUT_LANES; j++) begin
            packed_word[BW*j +: BW] = (4'(j) == 4'(r_acc_cnt)) ? cur_byte
                                                               : r_acc[BW*j +: BW];
        end

        o_status.slot_free  = slot_free;
        o_status.need_err   = r_finished && (is_put || is_fin);
        o_status.need_flush = !r_finished
                           && ((is_fin && ((r_kind == pbrle_pkg::KIND_REPEAT) || (r_len != '0)))
                            || (is_put && (rep_break || lit_break)));
        o_status.flush_done = advance && is_last;
    end

    always_comb begin
        n_len        = r_len;
        n_kind       = r_kind;
        n_finished   = r_finished;
        n_first      = r_first;
        n_prev       = r_prev;
        n_pend_byte  = r_pend_byte;
        n_pend_fin   = r_pend_fin;
        n_flush_rep  = r_flush_rep;
        n_last_pos   = r_last_pos;
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_acc_cnt    = r_acc_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_bytes  = r_out_bytes;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = i_in_byte;

        if (i_cmd.post_error && slot_free) begin
            n_out_valid  = 1'b1;
            n_out_bytes  = '0;
            n_out_count  = '0;
            n_out_last   = 1'b1;
            n_out_status = pbrle_pkg::STATUS_ERROR;
        end

        if (advance) begin
            n_pos = r_pos + PW'(1);
            if (completing) begin
                n_out_valid  = 1'b1;
                n_out_bytes  = packed_word;
                n_out_count  = 4'(r_acc_cnt) + 4'd1;
                n_out_last   = is_last;
                n_out_status = pbrle_pkg::STATUS_OK;
                n_acc        = '0;
                n_acc_cnt    = '0;
            end else begin
                n_acc     = packed_word;
                n_acc_cnt = r_acc_cnt + CW'(1);
            end
            if (is_last) begin
                if (r_pend_fin) begin
                    n_len      = '0;
                    n_kind     = pbrle_pkg::KIND_UNDET;
                    n_finished = 1'b1;
                end else begin
                    // the breaking byte opens the next run
                    mem_we  = 1'b1;
                    mem_wa  = '0;
                    mem_wd  = r_pend_byte;
                    n_len   = LW'(1);
                    n_kind  = pbrle_pkg::KIND_UNDET;
                    n_first = r_pend_byte;
                    n_prev  = r_pend_byte;
                end
            end
        end

        if (i_cmd.capture) begin
            n_pend_byte = i_in_byte;
            n_pend_fin  = is_fin;
            n_flush_rep = (r_kind == pbrle_pkg::KIND_REPEAT);
            n_last_pos  = (r_kind == pbrle_pkg::KIND_REPEAT) ? PW'(1) : PW'(r_len);
            n_pos       = '0;
            n_acc       = '0;
            n_acc_cnt   = '0;
        end

        if (i_cmd.apply) begin
            case (i_op)
                pbrle_pkg::OP_RESTART: begin
                    n_len      = '0;
                    n_kind     = pbrle_pkg::KIND_UNDET;
                    n_finished = 1'b0;
                end
                pbrle_pkg::OP_FINAL: begin
                    n_len      = '0;
                    n_kind     = pbrle_pkg::KIND_UNDET;
                    n_finished = 1'b1;
                end
                pbrle_pkg::OP_PUT: begin
                    case (r_kind)
                        pbrle_pkg::KIND_REPEAT: begin
                            n_len = r_len + LW'(1);
                        end
                        pbrle_pkg::KIND_LITERAL: begin
                            mem_we = 1'b1;
                            mem_wa = r_len[AW-1:0];
                            n_len  = r_len + LW'(1);
                            n_prev = i_in_byte;
                        end
                        default: begin
                            if (r_len == '0) begin
                                mem_we  = 1'b1;
                                mem_wa  = '0;
                                n_len   = LW'(1);
                                n_first = i_in_byte;
                                n_prev  = i_in_byte;
                            end else begin
                                mem_we  = 1'b1;
                                mem_wa  = AW'(1);
                                n_len   = LW'(2);
                                n_prev  = i_in_byte;
                                n_kind  = (r_first == i_in_byte) ? pbrle_pkg::KIND_REPEAT
                                                                 : pbrle_pkg::KIND_LITERAL;
                            end
                        end
                    endcase
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end

        // read one entry ahead so that r_mem_q always holds buffer[r_pos - 1]
        mem_ra = AW'(n_pos - PW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_kind      <= pbrle_pkg::KIND_UNDET;
            r_finished  <= 1'b0;
            r_pos       <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_kind      <= n_kind;
            r_finished  <= n_finished;
            r_pos       <= n_pos;
            r_acc_cnt   <= n_acc_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first      <= n_first;
        r_prev       <= n_prev;
        r_pend_byte  <= n_pend_byte;
        r_pend_fin   <= n_pend_fin;
        r_flush_rep  <= n_flush_rep;
        r_last_pos   <= n_last_pos;
        r_acc        <= n_acc;
        r_out_bytes  <= n_out_bytes;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_mem[mem_ra];
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_bytes  = r_out_bytes;
    assign o_out_count  = r_out_count;
    assign o_last       = r_out_last;
    assign o_status_bit = r_out_status;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the PackBits run-length encoder.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RUN          = 128;
    localparam int BYTES_PER_RESULT = 8;

    // Op code 3 has no meaning; the encoder must drop it without a trace.
    localparam logic [pbrle_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_BUDGET  = 430;  // counted input items before the stimulus stops
    localparam int IDLE_LIMIT   = 4000; // cycles without any transfer before giving up
    localparam int HOLD_AT      = 80;   // input transfers before the long output hold-off
    localparam int HOLD_CYCLES  = 300;  // length of that hold-off
    localparam int DRAIN_CYCLES = 300;  // quiet tail after the last expected chunk
    localparam int DIR_ROWS     = 25;

    // One output transfer: up to eight encoded bytes plus flags.
    typedef struct packed {
        logic [pbrle_pkg::OUT_W-1:0]       data;
        logic [pbrle_pkg::OUT_COUNT_W-1:0] count;
        logic                              last;
        logic                              status;
    } t_chunk;

    // One row of the directed table. Where typed is set, want replaces the prediction.
    typedef struct packed {
        logic [pbrle_pkg::OP_W-1:0]   op;
        logic [pbrle_pkg::BYTE_W-1:0] data;
        logic                         typed;
        t_chunk                       want;
    } t_row;

    localparam t_chunk NO_CHUNK  = '0;
    localparam t_chunk ERR_CHUNK = '{'0, '0, 1'b1, pbrle_pkg::STATUS_ERROR};

    logic                              i_clk;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic [pbrle_pkg::OP_W-1:0]        i_op        = pbrle_pkg::OP_PUT;
    logic [pbrle_pkg::BYTE_W-1:0]      i_in_byte   = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [pbrle_pkg::OUT_W-1:0]       o_out_bytes;
    logic [pbrle_pkg::OUT_COUNT_W-1:0] o_out_count;
    logic                              o_last;
    logic                              o_status;

    packbits_rle_encoder #(
        .MAX_RUN          (MAX_RUN),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_bytes (o_out_bytes),
        .o_out_count (o_out_count),
        .o_last      (o_last),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Encoder shadow: pending run, its kind and the finished flag.
    // ------------------------------------------------------------------
    logic [pbrle_pkg::BYTE_W-1:0] run_buf [0:MAX_RUN-1];
    int unsigned                  run_len     = 0;
    pbrle_pkg::t_kind             run_kind    = pbrle_pkg::KIND_UNDET;
    logic                         stream_done = 1'b0;

    logic [pbrle_pkg::BYTE_W-1:0] enc_bytes [$];   // encoded bytes of the run being closed
    t_chunk                       pending_chunks [$];

    int  n_fail     = 0;
    int  n_accepted = 0;
    int  items_sent = 0;
    bit  src_steady = 1'b0;
    bit  sink_steady = 1'b0;

    // Encode the pending run as header plus bytes, then cut it into chunks of
    // up to eight bytes, first byte in the low lane, last flag on the tail chunk.
    function automatic void close_run();
        logic [8:0] hdr;
        t_chunk     c;
        int         pos;
        int         k;
        enc_bytes.delete();
        if (run_kind == pbrle_pkg::KIND_REPEAT) begin
            hdr = 9'd257 - 9'(run_len);
            enc_bytes.push_back(hdr[7:0]);
            enc_bytes.push_back(run_buf[0]);
        end else begin
            enc_bytes.push_back(8'(run_len - 1));
            for (k = 0; k < int'(run_len); k++) enc_bytes.push_back(run_buf[k]);
        end
        pos = 0;
        while (pos < enc_bytes.size()) begin
            c = NO_CHUNK;
            for (k = 0; k < BYTES_PER_RESULT && pos < enc_bytes.size(); k++) begin
                c.data[8*k +: 8] = enc_bytes[pos];
                c.count = c.count + 4'd1;
                pos++;
            end
            c.last   = (pos >= enc_bytes.size());
            c.status = pbrle_pkg::STATUS_OK;
            pending_chunks.push_back(c);
        end
    endfunction

    function automatic void open_run(input logic [pbrle_pkg::BYTE_W-1:0] b);
        run_buf[0] = b;
        run_len    = 1;
        run_kind   = pbrle_pkg::KIND_UNDET;
    endfunction

    // Advance the shadow by one accepted input and queue the chunks it emits.
    function automatic void predict_packbits(input logic [pbrle_pkg::OP_W-1:0] op,
                                             input logic [pbrle_pkg::BYTE_W-1:0] b);
        if (op == pbrle_pkg::OP_RESTART) begin
            run_len     = 0;
            run_kind    = pbrle_pkg::KIND_UNDET;
            stream_done = 1'b0;
        end else if (op == OP_UNUSED) begin
            // dropped, state untouched
        end else if (stream_done) begin
            pending_chunks.push_back(ERR_CHUNK);
        end else if (op == pbrle_pkg::OP_FINAL) begin
            if (run_kind == pbrle_pkg::KIND_REPEAT || run_len > 0) close_run();
            run_len     = 0;
            run_kind    = pbrle_pkg::KIND_UNDET;
            stream_done = 1'b1;
        end else begin
            case (run_kind)
                pbrle_pkg::KIND_REPEAT: begin
                    if (run_len < MAX_RUN && b == run_buf[0]) begin
                        run_len++;
                    end else begin
                        close_run();
                        open_run(b);
                    end
                end
                pbrle_pkg::KIND_LITERAL: begin
                    if (run_len < MAX_RUN && b != run_buf[run_len-1]) begin
                        run_buf[run_len] = b;
                        run_len++;
                    end else begin
                        close_run();
                        open_run(b);
                    end
                end
                default: begin
                    // first two bytes of a run decide its kind
                    if (run_len == 0) begin
                        run_buf[0] = b;
                        run_len    = 1;
                    end else begin
                        run_buf[1] = b;
                        run_len    = 2;
                        run_kind   = (run_buf[0] == b) ? pbrle_pkg::KIND_REPEAT
                                                       : pbrle_pkg::KIND_LITERAL;
                    end
                end
            endcase
        end
    endfunction

    // Mostly no gap or a short one, now and then a long one; none in steady stretches.
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one item and hold it until the encoder takes it, then predict its output.
    task automatic send_item(input logic [pbrle_pkg::OP_W-1:0] op,
                             input logic [pbrle_pkg::BYTE_W-1:0] b);
        int gap;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_accepted++;
        if (op != OP_UNUSED) items_sent++;
        predict_packbits(op, b);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed table first, then random runs and stream events.
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_row                         rows [DIR_ROWS];
        int                           qsize;
        int                           seg;
        int                           pick;
        int                           len;
        int                           k;
        logic [pbrle_pkg::BYTE_W-1:0] b;
        logic [pbrle_pkg::BYTE_W-1:0] prev_b;

        rows = '{
            // finalize on empty run: nothing out
            '{pbrle_pkg::OP_FINAL,   8'h00, 1'b0, NO_CHUNK},
            // put after finalize
            '{pbrle_pkg::OP_PUT,     8'h00, 1'b1, ERR_CHUNK},
            // finalize after finalize
            '{pbrle_pkg::OP_FINAL,   8'hFF, 1'b1, ERR_CHUNK},
            // unused op, even while finished
            '{OP_UNUSED,             8'hA5, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_RESTART, 8'h5A, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'hFF, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'hFF, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_FINAL,   8'h00, 1'b1,
              '{64'hFFFF, 4'd2, 1'b1, pbrle_pkg::STATUS_OK}},
            '{pbrle_pkg::OP_PUT,     8'h00, 1'b1, ERR_CHUNK},
            '{pbrle_pkg::OP_RESTART, 8'h00, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'h00, 1'b0, NO_CHUNK},
            // lone byte
            '{pbrle_pkg::OP_FINAL,   8'h00, 1'b1,
              '{64'h0000, 4'd2, 1'b1, pbrle_pkg::STATUS_OK}},
            '{pbrle_pkg::OP_RESTART, 8'hFF, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'h80, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'h7F, 1'b0, NO_CHUNK},
            // equal byte breaks the literal
            '{pbrle_pkg::OP_PUT,     8'h7F, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'h7F, 1'b0, NO_CHUNK},
            // new byte breaks the repeat
            '{pbrle_pkg::OP_PUT,     8'h01, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'h01, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'h01, 1'b0, NO_CHUNK},
            // drop a pending repeat
            '{pbrle_pkg::OP_RESTART, 8'h00, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_PUT,     8'h42, 1'b0, NO_CHUNK},
            // drop a lone pending byte
            '{pbrle_pkg::OP_RESTART, 8'h00, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_FINAL,   8'h00, 1'b0, NO_CHUNK},
            '{pbrle_pkg::OP_RESTART, 8'h00, 1'b0, NO_CHUNK}
        };

        // hold reset, then release it once
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            qsize = pending_chunks.size();
            send_item(rows[r].op, rows[r].data);
            if (rows[r].typed) begin
                while (pending_chunks.size() > qsize) void'(pending_chunks.pop_back());
                pending_chunks.push_back(rows[r].want);
            end
        end

        // Random part: mostly runs of random content, short as a rule. The first
        // two segments are overlong so that both run kinds close at full size.
        prev_b = '0;
        seg    = 0;
        while (items_sent < ITEM_BUDGET) begin
            if ($urandom_range(0, 99) < 15) src_steady = ~src_steady;
            pick = (seg == 0) ? 0 : (seg == 1) ? 50 : $urandom_range(0, 99);
            len  = (seg < 2) ? $urandom_range(MAX_RUN + 1, MAX_RUN + 6) :
                   ($urandom_range(0, 99) < 6) ? $urandom_range(MAX_RUN - 8, MAX_RUN + 8) :
                   $urandom_range(1, 10);
            if (pick < 40) begin
                // repeat run
                b = 8'($urandom_range(0, 255));
                for (k = 0; k < len; k++) send_item(pbrle_pkg::OP_PUT, b);
                prev_b = b;
            end else if (pick < 80) begin
                // literal run: each byte differs from the one before it
                for (k = 0; k < len; k++) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == prev_b) b = b + 8'd1;
                    send_item(pbrle_pkg::OP_PUT, b);
                    prev_b = b;
                end
            end else if (pick < 88) begin
                // finish the stream, sometimes poke it afterwards, then reopen
                send_item(pbrle_pkg::OP_FINAL, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) begin
                    send_item(pbrle_pkg::OP_PUT, 8'($urandom_range(0, 255)));
                    send_item(pbrle_pkg::OP_FINAL, 8'($urandom_range(0, 255)));
                end
                send_item(pbrle_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                send_item(pbrle_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
            end else if (pick < 97) begin
                send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
            end else begin
                send_item(pbrle_pkg::OP_PUT, 8'($urandom_range(0, 255)));
            end
            seg++;
        end
        i_in_valid <= 1'b0;

        // drain: wait for every expected chunk, then watch a quiet tail
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random backpressure with one long hold-off while the
    // sender keeps offering, so the encoder fills and stalls its input.
    // ------------------------------------------------------------------
    initial begin : out_sink
        int stall;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < 3) sink_steady = ~sink_steady;
            if (!held && n_accepted >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = pick_gap(sink_steady);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each output transfer against the oldest expected chunk.
    always @(posedge i_clk) begin : chunk_check
        t_chunk want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chunks.size() == 0) begin
                $error("unexpected output transfer: bytes=%h count=%0d last=%b status=%b",
                       o_out_bytes, o_out_count, o_last, o_status);
                n_fail++;
            end else begin
                want = pending_chunks.pop_front();
                if (o_out_bytes !== want.data) begin
                    $error("out_bytes: expected %h, got %h", want.data, o_out_bytes);
                    n_fail++;
                end
                if (o_out_count !== want.count) begin
                    $error("out_count: expected %0d, got %0d", want.count, o_out_count);
                    n_fail++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    n_fail++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %b, got %b", want.status, o_status);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: give up after too many cycles with no transfer on either side.
    always @(posedge i_clk) begin : watchdog
        int idle;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle = 0;
        end else begin
            idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
